// File: sv/history_ring_with_cursor_defines.svh
// Assertion macros shared by the history ring RTL.
// Used by hrc_ctrl and hrc_datapath; expects clk and rst_n in scope.
`ifndef HISTORY_RING_WITH_CURSOR_DEFINES_SVH
`define HISTORY_RING_WITH_CURSOR_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define HRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrc assertion failed");
// next-cycle implication
`define HRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrc assertion failed");
`else
`define HRC_ASSERT_NOW(label, ante, cons)
`define HRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/hrc_pkg.sv
// Package for the history ring: payload structs, op codes, FSM states,
// controller command struct. No dependencies.
package hrc_pkg;

    localparam int MAX_DEPTH   = 64;
    localparam int ENTRY_WIDTH = 32;
    localparam int SLOT_W      = 6;
    localparam int CNT_W       = 7;
    localparam int STEP_W      = 8;
    localparam int OP_W        = 3;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_SEEK_BACK = 3'd1;
    localparam logic [OP_W-1:0] OP_SEEK_FWD  = 3'd2;
    localparam logic [OP_W-1:0] OP_LATEST    = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [STEP_W-1:0]      step;
        logic [ENTRY_WIDTH-1:0] entry_data;
    } in_t;

    typedef struct packed {
        logic                   status;
        logic                   has_entries;
        logic [ENTRY_WIDTH-1:0] current_entry;
        logic [ENTRY_WIDTH-1:0] newest_entry;
        logic [CNT_W-1:0]       entry_count;
        logic [SLOT_W-1:0]      cursor_position;
    } out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;   // latch the incoming item
        logic exec;   // update pointers, write on append
        logic rd;     // read the entry under the cursor
        logic clear;  // capacity write, empty the store
    } cmd_t;

endpackage

// File: sv/hrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/hrc_ctrl.sv
// Controller FSM for the history ring: sequences load, update, read, respond.
// Depends on hrc_pkg and history_ring_with_cursor_defines.svh.
`include "history_ring_with_cursor_defines.svh"
module hrc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    output logic          busy,
    output logic          done,
    output hrc_pkg::cmd_t cmd
);

    hrc_pkg::state_t state_reg;
    hrc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hrc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            hrc_pkg::S_IDLE:
            begin
                busy      = 1'b0;
                cfg_ready = !start;
                cmd.clear = cfg_valid && !start;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = hrc_pkg::S_EXEC;
                end
            end
            hrc_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = hrc_pkg::S_READ;
            end
            hrc_pkg::S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = hrc_pkg::S_DONE;
            end
            hrc_pkg::S_DONE:
            begin
                done       = 1'b1;
                state_next = hrc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = hrc_pkg::S_IDLE;
            end
        endcase
    end

    `HRC_ASSERT_NEXT(a_load_then_exec, cmd.load, cmd.exec)
    `HRC_ASSERT_NEXT(a_read_then_done, cmd.rd, done)
    `HRC_ASSERT_NEXT(a_done_then_idle, done, !busy && !done)

endmodule

// File: sv/hrc_datapath.sv
// Datapath for the history ring: pointers, count, capacity, newest entry
// and the entry RAM. Depends on hrc_pkg, hrc_ram and the defines header.
`include "history_ring_with_cursor_defines.svh"
module hrc_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hrc_pkg::cmd_t             cmd,
    input  hrc_pkg::in_t              item,
    input  logic [hrc_pkg::CNT_W-1:0] cfg_data,
    output hrc_pkg::out_t             result
);

    localparam logic [hrc_pkg::CNT_W-1:0] CAP_MAX = hrc_pkg::CNT_W'(hrc_pkg::MAX_DEPTH);

    logic [hrc_pkg::CNT_W-1:0]       cap_reg, cap_next;
    logic [hrc_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [hrc_pkg::SLOT_W-1:0]      oldest_reg, oldest_next;
    logic [hrc_pkg::SLOT_W-1:0]      cursor_reg, cursor_next;
    logic                            status_reg, status_next;
    logic [hrc_pkg::ENTRY_WIDTH-1:0] newest_reg, newest_next;
    hrc_pkg::in_t                    item_reg;

    logic [hrc_pkg::CNT_W-1:0]       eff_cap;
    logic                            full;
    logic                            empty;
    logic [hrc_pkg::STEP_W-1:0]      cur_ext;
    logic [hrc_pkg::STEP_W-1:0]      avail;
    logic                            ram_we;
    logic [hrc_pkg::SLOT_W-1:0]      wr_slot;
    logic [hrc_pkg::SLOT_W-1:0]      rd_slot;
    logic [hrc_pkg::ENTRY_WIDTH-1:0] ram_rdata;

    // zero acts as one, above the depth saturates
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = hrc_pkg::CNT_W'(1);
        end
        else if (cap_reg > CAP_MAX)
        begin
            eff_cap = CAP_MAX;
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    assign full    = count_reg >= eff_cap;
    assign empty   = count_reg == '0;
    assign cur_ext = hrc_pkg::STEP_W'(cursor_reg);
    // room ahead of the cursor; only used when not empty
    assign avail   = hrc_pkg::STEP_W'(count_reg) - hrc_pkg::STEP_W'(1) - cur_ext;
    // with eviction the slot is (oldest+1)+(count-1), same as oldest+count
    assign wr_slot = oldest_reg + count_reg[hrc_pkg::SLOT_W-1:0];
    assign rd_slot = oldest_reg + cursor_reg;
    assign ram_we  = cmd.exec && (item_reg.op == hrc_pkg::OP_APPEND);

    always_comb
    begin
        cap_next    = cap_reg;
        count_next  = count_reg;
        oldest_next = oldest_reg;
        cursor_next = cursor_reg;
        status_next = status_reg;
        newest_next = newest_reg;
        if (cmd.clear)
        begin
            cap_next    = cfg_data;
            count_next  = '0;
            oldest_next = '0;
            cursor_next = '0;
        end
        else if (cmd.exec)
        begin
            status_next = hrc_pkg::ST_OK;
            case (item_reg.op)
                hrc_pkg::OP_APPEND:
                begin
                    if (full)
                    begin
                        oldest_next = oldest_reg + hrc_pkg::SLOT_W'(1);
                    end
                    else
                    begin
                        count_next = count_reg + hrc_pkg::CNT_W'(1);
                    end
                    cursor_next = hrc_pkg::SLOT_W'(count_next - hrc_pkg::CNT_W'(1));
                    newest_next = item_reg.entry_data;
                end
                hrc_pkg::OP_SEEK_BACK:
                begin
                    if (empty || (item_reg.step > cur_ext))
                    begin
                        status_next = hrc_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        cursor_next = cursor_reg - hrc_pkg::SLOT_W'(item_reg.step);
                    end
                end
                hrc_pkg::OP_SEEK_FWD:
                begin
                    if (empty || (item_reg.step > avail))
                    begin
                        status_next = hrc_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        cursor_next = cursor_reg + hrc_pkg::SLOT_W'(item_reg.step);
                    end
                end
                hrc_pkg::OP_LATEST:
                begin
                    if (!empty)
                    begin
                        cursor_next = hrc_pkg::SLOT_W'(count_reg - hrc_pkg::CNT_W'(1));
                    end
                end
                default:
                begin
                    // query and unused codes: no change
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_MAX;
            count_reg  <= '0;
            oldest_reg <= '0;
            cursor_reg <= '0;
            status_reg <= hrc_pkg::ST_OK;
        end
        else
        begin
            cap_reg    <= cap_next;
            count_reg  <= count_next;
            oldest_reg <= oldest_next;
            cursor_reg <= cursor_next;
            status_reg <= status_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        newest_reg <= newest_next;
        if (cmd.load)
        begin
            item_reg <= item;
        end
    end

    hrc_ram #(
        .WIDTH (hrc_pkg::ENTRY_WIDTH),
        .DEPTH (hrc_pkg::MAX_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_slot),
        .wdata (item_reg.entry_data),
        .re    (cmd.rd),
        .raddr (rd_slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        result        = '0;
        result.status = status_reg;
        if (!empty)
        begin
            result.has_entries     = 1'b1;
            result.current_entry   = ram_rdata;
            result.newest_entry    = newest_reg;
            result.entry_count     = count_reg;
            result.cursor_position = cursor_reg;
        end
    end

    `HRC_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= CAP_MAX)
    `HRC_ASSERT_NOW(a_cursor_in_range, !empty,
        hrc_pkg::CNT_W'(cursor_reg) < count_reg)
    `HRC_ASSERT_NEXT(a_clear_empties, cmd.clear, empty && (cursor_reg == '0))

endmodule

// File: sv/history_ring_with_cursor.sv
// Top level of the history ring with browsing cursor.
// Depends on hrc_pkg, hrc_ctrl, hrc_datapath (which holds hrc_ram).
//
// Usage:
//   Command channel: drive item and raise start; the beat is taken at a
//   rising edge with start high and busy low. busy stays high until the
//   result has been shown.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot stall it, so it must capture the beat then.
//   Config channel: cfg_data (capacity, 7 bits) is taken when cfg_valid
//   and cfg_ready are both high. cfg_ready is high only while idle and no
//   command is starting. A write empties the store and homes the cursor.
//   Sequence: done rises after the update and read states; a new
//   command is taken only back in idle, after the controller sequence
//   (update pointers and write, read the cursor entry from the RAM,
//   present the result, return to idle).
//   Reset: store empty, cursor and oldest slot at zero, capacity 64.
//   No clearing pass; empty slots never reach the result.
module history_ring_with_cursor (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  hrc_pkg::in_t              item,
    output logic                      done,
    output hrc_pkg::out_t             result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [hrc_pkg::CNT_W-1:0] cfg_data
);

    hrc_pkg::cmd_t cmd;

    // sequencing only; no payload passes through here
    hrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd)
    );

    // pointers, count, capacity and the entry RAM
    hrc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (item),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

// File: tb/tb_history_ring_with_cursor.sv
// Self-checking testbench for history_ring_with_cursor: directed, wrap and random tests.
// Needs hrc_pkg and the history ring RTL; the expected beats come from an in-bench predictor.
`timescale 1ns / 1ps

module tb_history_ring_with_cursor;

    localparam int CLK_HALF    = 2;     // 4 ns period
    localparam int RESET_CYC   = 9;
    localparam int DRAIN_CYC   = 8;     // margin for done to land after the last accept
    localparam int STALL_LIMIT = 5000;  // cycles with no handshake at all before giving up
    localparam int RAND_ITEMS  = 1150;
    localparam int RAND_PHASES = 8;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    hrc_pkg::in_t              item;
    logic                      done;
    hrc_pkg::out_t             result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [hrc_pkg::CNT_W-1:0] cfg_data;

    history_ring_with_cursor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: its own copy of the ring, pointers and capacity.
    // Advanced at each accepted command beat, so the pending queue always
    // holds results in command order.
    // ------------------------------------------------------------------
    logic [hrc_pkg::ENTRY_WIDTH-1:0] hist_mem [hrc_pkg::MAX_DEPTH];
    logic [hrc_pkg::SLOT_W-1:0]      hist_oldest;
    int unsigned                     hist_count;
    int unsigned                     hist_cursor;
    logic [hrc_pkg::CNT_W-1:0]       hist_capacity;

    hrc_pkg::out_t pending_results[$];
    hrc_pkg::out_t want_beat;

    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned cap_writes;
    int unsigned error_count;
    int unsigned quiet_cycles;
    bit          no_gaps;          // set for gap-free stretches of the random test

    function automatic int unsigned ring_slot(int unsigned offset);
        return (hist_oldest + offset) % hrc_pkg::MAX_DEPTH;
    endfunction

    function automatic void clear_history(logic [hrc_pkg::CNT_W-1:0] cap);
        hist_capacity = cap;
        hist_oldest   = '0;
        hist_count    = 0;
        hist_cursor   = 0;
    endfunction

    // Applies one command to the predictor and returns the beat it should produce.
    function automatic hrc_pkg::out_t predict_history(hrc_pkg::in_t cmd);
        hrc_pkg::out_t r;
        int unsigned   limit;
        limit = (hist_capacity == 0) ? 1 :
                (hist_capacity > hrc_pkg::MAX_DEPTH) ? hrc_pkg::MAX_DEPTH : hist_capacity;
        r = '0;
        r.status = hrc_pkg::ST_OK;
        case (cmd.op)
            hrc_pkg::OP_APPEND:
            begin
                // full store: drop the oldest, cursor follows its entry down
                if (hist_count >= limit)
                begin
                    hist_oldest = hist_oldest + 1'b1;
                    hist_count--;
                    if (hist_cursor > 0)
                        hist_cursor--;
                end
                hist_mem[ring_slot(hist_count)] = cmd.entry_data;
                hist_count++;
                hist_cursor = hist_count - 1;
            end
            hrc_pkg::OP_SEEK_BACK:
            begin
                if (hist_count == 0 || cmd.step > hist_cursor)
                    r.status = hrc_pkg::ST_NOT_FOUND;
                else
                    hist_cursor -= cmd.step;
            end
            hrc_pkg::OP_SEEK_FWD:
            begin
                if (hist_count == 0 || cmd.step > (hist_count - 1) - hist_cursor)
                    r.status = hrc_pkg::ST_NOT_FOUND;
                else
                    hist_cursor += cmd.step;
            end
            hrc_pkg::OP_LATEST:
            begin
                if (hist_count > 0)
                    hist_cursor = hist_count - 1;
            end
            default: ;  // query and the unused codes change nothing
        endcase
        if (hist_count > 0)
        begin
            r.has_entries     = 1'b1;
            r.current_entry   = hist_mem[ring_slot(hist_cursor)];
            r.newest_entry    = hist_mem[ring_slot(hist_count - 1)];
            r.entry_count     = hist_count[hrc_pkg::CNT_W-1:0];
            r.cursor_position = hist_cursor[hrc_pkg::SLOT_W-1:0];
        end
        return r;
    endfunction

    function automatic hrc_pkg::in_t mk_item(logic [hrc_pkg::OP_W-1:0] op, int unsigned step,
                                             logic [hrc_pkg::ENTRY_WIDTH-1:0] data);
        hrc_pkg::in_t c;
        c.op         = op;
        c.step       = step[hrc_pkg::STEP_W-1:0];
        c.entry_data = data;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Command side. Inputs change on the falling edge; busy is sampled on
    // the rising edge. start is left high after a beat: the next call
    // either loads a new item on the next falling edge or the gap task
    // drops it, so start never sees two assignments in one step.
    // ------------------------------------------------------------------
    task automatic send_command(hrc_pkg::in_t cmd);
        @(negedge clk);
        start <= 1'b1;
        item  <= cmd;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_results = {pending_results, predict_history(cmd)};
        items_sent++;
    endtask

    // Idle the command side with start low (n == 0 keeps start high for back-to-back).
    task automatic hold_off(int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Mostly short gaps, a few long ones so they land on every controller phase.
    task automatic random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps)
            hold_off(0);
        else if (r < 55)
            hold_off(0);
        else if (r < 85)
            hold_off($urandom_range(1, 3));
        else if (r < 97)
            hold_off($urandom_range(4, 10));
        else
            hold_off($urandom_range(20, 60));
    endtask

    // Capacity write: only with the block idle, i.e. start low, all results
    // back and the controller given time to settle.
    task automatic set_capacity(logic [hrc_pkg::CNT_W-1:0] cap);
        hold_off(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        clear_history(cap);
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: the block cannot be stalled, so every done cycle is a
    // beat and is checked against the oldest pending prediction.
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [hrc_pkg::ENTRY_WIDTH-1:0] exp_v,
                                 logic [hrc_pkg::ENTRY_WIDTH-1:0] got_v);
        if (got_v !== exp_v)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: unexpected result beat, expected none, actual %p",
                         $time, result);
            end
            else
            begin
                want_beat = pending_results[0];
                pending_results.delete(0);
                compare_field("status",
                              hrc_pkg::ENTRY_WIDTH'(want_beat.status),
                              hrc_pkg::ENTRY_WIDTH'(result.status));
                compare_field("has_entries",
                              hrc_pkg::ENTRY_WIDTH'(want_beat.has_entries),
                              hrc_pkg::ENTRY_WIDTH'(result.has_entries));
                compare_field("current_entry", want_beat.current_entry,
                              result.current_entry);
                compare_field("newest_entry", want_beat.newest_entry,
                              result.newest_entry);
                compare_field("entry_count",
                              hrc_pkg::ENTRY_WIDTH'(want_beat.entry_count),
                              hrc_pkg::ENTRY_WIDTH'(result.entry_count));
                compare_field("cursor_position",
                              hrc_pkg::ENTRY_WIDTH'(want_beat.cursor_position),
                              hrc_pkg::ENTRY_WIDTH'(result.cursor_position));
            end
        end
    end

    // Watchdog: any handshake on any channel resets the count.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("[history_ring_with_cursor] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty store, every op code, seek limits, zero capacity, small ring eviction.
    task automatic test_directed();
        send_command(mk_item(hrc_pkg::OP_QUERY, 0, '0));             // empty store
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 0, '0));         // seek on empty fails
        send_command(mk_item(hrc_pkg::OP_SEEK_FWD, 0, '0));
        send_command(mk_item(hrc_pkg::OP_LATEST, 255, '1));          // latest on empty is ok
        send_command(mk_item(3'd7, 0, '0));                          // unused code acts as query
        send_command(mk_item(hrc_pkg::OP_APPEND, 0, 32'h0000_0000));
        send_command(mk_item(hrc_pkg::OP_APPEND, 255, 32'hFFFF_FFFF));
        send_command(mk_item(hrc_pkg::OP_APPEND, 0, 32'hA5A5_5A5A));
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 2, '0));         // to oldest
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 1, '0));         // below oldest: not found
        send_command(mk_item(hrc_pkg::OP_SEEK_FWD, 255, '0));        // far out of range
        send_command(mk_item(hrc_pkg::OP_SEEK_FWD, 2, '0));          // exactly to newest
        send_command(mk_item(hrc_pkg::OP_SEEK_FWD, 0, '0));
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 1, '0));
        send_command(mk_item(3'd5, 0, '0));
        send_command(mk_item(3'd6, 0, '0));
        send_command(mk_item(hrc_pkg::OP_LATEST, 0, '0));
        // capacity zero behaves as one; the write also empties the store
        set_capacity('0);
        send_command(mk_item(hrc_pkg::OP_QUERY, 0, '0));
        send_command(mk_item(hrc_pkg::OP_APPEND, 0, 32'h1234_5678));
        send_command(mk_item(hrc_pkg::OP_APPEND, 0, 32'h8765_4321));
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 1, '0));
        set_capacity(7'd2);
        send_command(mk_item(hrc_pkg::OP_APPEND, 0, 32'hCAFE_0001));
        send_command(mk_item(hrc_pkg::OP_APPEND, 0, 32'hCAFE_0002));
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 1, '0));         // cursor on oldest
        send_command(mk_item(hrc_pkg::OP_APPEND, 0, 32'hCAFE_0003)); // evict under the cursor
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 1, '0));
    endtask

    // Full-depth ring: capacity above the depth saturates, pointers wrap.
    task automatic test_full_wrap();
        int i;
        set_capacity(7'd127);
        for (i = 0; i < hrc_pkg::MAX_DEPTH + 6; i++)
        begin
            send_command(mk_item(hrc_pkg::OP_APPEND, $urandom_range(0, 255), $urandom()));
            random_gap();
        end
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, hrc_pkg::MAX_DEPTH - 1, '0));  // to oldest
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 1, '0));
        send_command(mk_item(hrc_pkg::OP_SEEK_FWD, hrc_pkg::MAX_DEPTH, '0));       // one too far
        send_command(mk_item(hrc_pkg::OP_SEEK_FWD, hrc_pkg::MAX_DEPTH - 1, '0));
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 17, '0));
        send_command(mk_item(hrc_pkg::OP_APPEND, 0, $urandom()));  // evict, cursor off newest
        send_command(mk_item(hrc_pkg::OP_SEEK_BACK, 40, '0));
        send_command(mk_item(hrc_pkg::OP_LATEST, 0, '0));
        set_capacity(7'd64);
        send_command(mk_item(hrc_pkg::OP_QUERY, 0, '0));
    endtask

    // Seek distance aimed mostly at the live range and its edges.
    function automatic int unsigned pick_step(bit fwd);
        int unsigned room;
        int unsigned r;
        room = fwd ? ((hist_count > 0) ? hist_count - 1 - hist_cursor : 0) : hist_cursor;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, room);
        else if (r < 75)
            return room;
        else if (r < 85)
            return room + 1;
        else
            return $urandom_range(0, 255);
    endfunction

    function automatic hrc_pkg::in_t random_command();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 32)
            return mk_item(hrc_pkg::OP_APPEND, $urandom_range(0, 255), $urandom());
        else if (r < 54)
            return mk_item(hrc_pkg::OP_SEEK_BACK, pick_step(1'b0), $urandom());
        else if (r < 76)
            return mk_item(hrc_pkg::OP_SEEK_FWD, pick_step(1'b1), $urandom());
        else if (r < 86)
            return mk_item(hrc_pkg::OP_LATEST, $urandom_range(0, 255), $urandom());
        else if (r < 95)
            return mk_item(hrc_pkg::OP_QUERY, $urandom_range(0, 255), $urandom());
        else
            return mk_item(hrc_pkg::OP_W'($urandom_range(5, 7)), $urandom_range(0, 255),
                           $urandom());
    endfunction

    // Random phases, each under its own capacity; a few run with no gaps.
    task automatic test_random();
        logic [hrc_pkg::CNT_W-1:0] phase_cap [RAND_PHASES];
        int                        p;
        int                        i;
        phase_cap = '{7'd1, 7'd0, 7'd3, 7'd127, 7'd8, 7'd64,
                      7'($urandom_range(0, 127)), 7'($urandom_range(2, 20))};
        for (p = 0; p < RAND_PHASES; p++)
        begin
            set_capacity(phase_cap[p]);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (i = 0; i < RAND_ITEMS / RAND_PHASES; i++)
            begin
                send_command(random_command());
                random_gap();
            end
            no_gaps = 1'b0;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start       <= 1'b0;
        item        <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        items_sent   = 0;
        results_seen = 0;
        cap_writes   = 0;
        error_count  = 0;
        no_gaps      = 1'b0;
        clear_history(7'd64);
        repeat (RESET_CYC) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_wrap();
        test_random();

        hold_off(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Ran %0d commands over %0d capacity settings, %0d result beats checked.",
                 items_sent, cap_writes, results_seen);
        if (error_count == 0)
            $display("[history_ring_with_cursor] OK");
        else
            $display("[history_ring_with_cursor] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/hrc_pkg.sv
sv/hrc_ram.sv
sv/hrc_ctrl.sv
sv/hrc_datapath.sv
sv/history_ring_with_cursor.sv
tb/tb_history_ring_with_cursor.sv
